// ----- design/iov_pkg.sv -----
`timescale 1ns / 1ps

package iov_pkg;

	localparam int unsigned SLOT_IDX_W = 8;
	localparam int unsigned REF_W      = 16;
	localparam int unsigned POS_W      = 31;
	localparam int unsigned COUNT_W    = 9;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic                  req_type;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [REF_W-1:0]      ref_id;
		logic [POS_W-1:0]      start_pos;
		logic [POS_W-1:0]      end_pos;
		logic                  is_mapped;
	} req_t;

	typedef struct packed {
		logic [SLOT_IDX_W-1:0] match_slot;
		logic                  match_valid;
		logic                  overflow;
		logic                  last_of_run;
	} rsp_t;

	// One table entry as it sits in a cell of the ring.
	typedef struct packed {
		logic [REF_W-1:0] ref_id;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] end_pos;
	} slot_t;

	typedef struct packed {
		logic shift;
		logic load;
	} ring_ctl_t;

endpackage

// ----- design/iov_cell.sv -----
`timescale 1ns / 1ps

module iov_cell
	import iov_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  logic  load,
	input  slot_t load_data,
	input  slot_t nbr,
	output slot_t cur
);

	slot_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_data;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign cur = entry_q;

endmodule

// ----- design/iov_ctrl.sv -----
`timescale 1ns / 1ps

module iov_ctrl
	import iov_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned MAX_MATCHES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  req_t               in_data,
	input  slot_t              head,
	output ring_ctl_t          ring,
	output logic               out_valid,
	input  logic               out_stall,
	output rsp_t               out_data
);

	localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CMP_W  = (SLOT_W > COUNT_W) ? SLOT_W : COUNT_W;
	localparam int unsigned CNT_W  = $clog2(MAX_MATCHES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic [COUNT_W-1:0]      entry_count_q;
	logic [SLOT_W-1:0]       pos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pend_v_q;
	logic [SLOT_IDX_W-1:0]   pend_slot_q;
	logic                    dropped_q;
	logic [REF_W-1:0]        q_ref_q;
	logic [POS_W-1:0]        q_start_q;
	logic [POS_W-1:0]        q_end_q;
	logic                    q_mapped_q;
	logic                    out_v_q;
	rsp_t                    out_data_q;

	logic                    accept;
	logic                    out_free;
	logic [SLOT_W+7:0]       pos_wide;
	logic [SLOT_IDX_W-1:0]   pos8;
	logic                    in_range;
	logic                    hit;
	logic                    full;
	logic                    need_push;
	logic                    adv;
	logic                    at_end;
	logic                    out_load;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_v_q || !out_stall;

	assign pos_wide = {8'b0, pos_q};
	assign pos8     = pos_wide[7:0];

	// Slots at or beyond the loaded count rotate past the head without a compare.
	assign in_range = CMP_W'(pos_q) < CMP_W'(entry_count_q);

	assign hit = q_mapped_q && in_range && (head.ref_id == q_ref_q)
		&& (q_start_q <= q_end_q) && (head.start_pos <= head.end_pos)
		&& (head.start_pos <= q_end_q) && (q_start_q <= head.end_pos);

	assign full      = (cnt_q == CNT_W'(MAX_MATCHES));
	assign need_push = hit && !full && pend_v_q;
	assign adv       = (state_q == ST_SCAN) && (!need_push || out_free);
	assign at_end    = (pos_q == SLOT_W'(TABLE_DEPTH - 1));

	// The output register only takes a new beat when it is free.
	assign out_load = (adv && need_push) || ((state_q == ST_DONE) && out_free);

	assign ring.shift = adv;
	assign ring.load  = accept && (in_data.req_type == REQ_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			dropped_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q <= out_load;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_data.req_type == REQ_QUERY)) begin
						state_q   <= ST_SCAN;
						pos_q     <= '0;
						cnt_q     <= '0;
						pend_v_q  <= 1'b0;
						dropped_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						pos_q <= pos_q + SLOT_W'(1);
						if (hit) begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								pend_v_q <= 1'b1;
								cnt_q    <= cnt_q + CNT_W'(1);
							end
						end
						if (at_end) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_data.req_type == REQ_QUERY)) begin
			q_ref_q    <= in_data.ref_id;
			q_start_q  <= in_data.start_pos;
			q_end_q    <= in_data.end_pos;
			q_mapped_q <= in_data.is_mapped;
		end
		if (adv && hit && !full) begin
			pend_slot_q <= pos8;
			if (pend_v_q) begin
				out_data_q.match_slot  <= pend_slot_q;
				out_data_q.match_valid <= 1'b1;
				out_data_q.overflow    <= 1'b0;
				out_data_q.last_of_run <= 1'b0;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			// The held match becomes the final beat; with none held, report no match.
			out_data_q.match_slot  <= pend_v_q ? pend_slot_q : '0;
			out_data_q.match_valid <= pend_v_q;
			out_data_q.overflow    <= pend_v_q && dropped_q;
			out_data_q.last_of_run <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/interval_overlap_query.sv -----
`timescale 1ns / 1ps

// Interval overlap table. The table lives in a ring of TABLE_DEPTH cells; a load beat writes
// one cell and is followed at once by the next beat. A query beat turns the ring one full
// revolution, one cell past the shared comparator per cycle while no match waits on a stalled
// output. Matches come out in ascending slot order, the last one marked; an unmapped query or one
// that finds nothing gives a single no-match beat. After MAX_MATCHES matches the rest are dropped
// and overflow is set on the final beat. The next beat is taken while the final result still
// waits on output. The user must write entry_count only between queries; the block itself does
// not enforce it.
module interval_overlap_query
	import iov_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned MAX_MATCHES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  req_t               in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rsp_t               out_data
);

	slot_t     cell_out [TABLE_DEPTH];
	slot_t     load_data;
	ring_ctl_t ring;

	assign load_data.ref_id    = in_data.ref_id;
	assign load_data.start_pos = in_data.start_pos;
	assign load_data.end_pos   = in_data.end_pos;

	// Each cell takes its upper neighbor on a shift; the top cell takes the head, closing the ring.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		iov_cell u_cell (
			.clk       (clk),
			.shift     (ring.shift),
			.load      (ring.load && (32'(in_data.slot_index) == i)),
			.load_data (load_data),
			.nbr       (cell_out[(i + 1) % TABLE_DEPTH]),
			.cur       (cell_out[i])
		);
	end

	iov_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_MATCHES (MAX_MATCHES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.head        (cell_out[0]),
		.ring        (ring),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

// ----- design/iov_checker.sv -----
`timescale 1ns / 1ps

module iov_checker
	import iov_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input req_t               in_data,
	input logic               out_valid,
	input logic               out_stall,
	input rsp_t               out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.req_type == REQ_QUERY) |=> in_stall)
		else $error("input taken right after a query");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.req_type == REQ_LOAD) |=> !in_stall)
		else $error("load did not finish in one cycle");

	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.match_valid |-> out_data.last_of_run)
		else $error("no-match beat not marked last");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.last_of_run && out_data.match_valid)
		else $error("overflow on a beat that is not the final match");

endmodule

bind interval_overlap_query iov_checker u_iov_checker (.*);
